/* design/avcc_pkg.sv */
// Shared types and constants for the configuration record to Annex B converter.
package avcc_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_RECORD_SIZE = 2'd0;
    localparam logic [1:0] REG_PAD_BYTES   = 2'd1;

    localparam logic [5:0] PAD_MAX = 6'd32;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } avcc_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        last;
        logic [2:0]  nal_length_size;
        logic [24:0] byte_total;
        logic        sps_found;
        logic        pps_found;
    } avcc_out_t;

    // Completion info carried on a done item
    typedef struct packed {
        logic [2:0]  nal_length_size;
        logic [24:0] byte_total;
        logic        sps_found;
        logic        pps_found;
    } avcc_info_t;

    // One request from the parser to the emitter: the results of one input byte
    typedef struct packed {
        logic       start_code;
        logic       data_en;
        logic [7:0] data;
        logic [5:0] pad_cnt;
        logic       done;
        logic       err;
        avcc_info_t info;
    } avcc_cmd_t;

endpackage

/* design/avcc_front.sv */
// Record parser: takes a byte per cycle unless the queue is full and classifies it.
module avcc_front
    import avcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  avcc_in_t    in_data,
    input  logic [19:0] record_size,
    input  logic [5:0]  pad_bytes,
    input  logic        cmd_full,
    output logic        cmd_push,
    output avcc_cmd_t   cmd
);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_LENSZ,
        PH_SPSCNT,
        PH_ULEN_HI,
        PH_ULEN_LO,
        PH_DATA,
        PH_PPSCNT,
        PH_DRAIN
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [19:0] pos_reg, pos_next;
    logic [7:0]  units_left_reg, units_left_next;
    logic        in_pps_list_reg, in_pps_list_next;
    logic [15:0] unit_length_reg, unit_length_next;
    logic [15:0] data_left_reg, data_left_next;
    logic [24:0] total_reg, total_next;
    logic [2:0]  lfs_reg, lfs_next;
    logic        sps_reg, sps_next;
    logic        pps_reg, pps_next;

    logic        accept;
    logic        finished;
    logic        failed;
    logic        unit_done;
    logic [15:0] unit_len_full;
    logic [20:0] bound;
    logic [24:0] total_sum;
    logic [7:0]  b;

    assign in_ready = !cmd_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_data.in_byte;

    // Work out next parse state and this byte's emit request
    always_comb
    begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        units_left_next  = units_left_reg;
        in_pps_list_next = in_pps_list_reg;
        unit_length_next = unit_length_reg;
        data_left_next   = data_left_reg;
        total_next       = total_reg;
        lfs_next         = lfs_reg;
        sps_next         = sps_reg;
        pps_next         = pps_reg;
        cmd              = '0;
        finished         = 1'b0;
        failed           = 1'b0;
        unit_done        = 1'b0;
        unit_len_full    = {unit_length_reg[15:8], b};
        bound            = {1'b0, pos_reg} + 21'd1 + {5'd0, unit_len_full};
        total_sum        = total_reg + {9'd0, unit_len_full} + 25'd4;

        unique case (phase_reg)
            PH_HDR:
            begin
                if (pos_reg >= 20'd3)
                    phase_next = PH_LENSZ;
            end
            PH_LENSZ:
            begin
                lfs_next   = {1'b0, b[1:0]} + 3'd1;
                phase_next = PH_SPSCNT;
            end
            PH_SPSCNT:
            begin
                units_left_next  = {3'd0, b[4:0]};
                in_pps_list_next = 1'b0;
                if (b[4:0] != 5'd0)
                begin
                    sps_next   = 1'b1;
                    phase_next = PH_ULEN_HI;
                end
                else
                begin
                    phase_next = PH_PPSCNT;
                end
            end
            PH_ULEN_HI:
            begin
                unit_length_next = {b, 8'd0};
                phase_next       = PH_ULEN_LO;
            end
            PH_ULEN_LO:
            begin
                unit_length_next = unit_len_full;
                if (bound > {1'b0, record_size})
                begin
                    failed = 1'b1;
                end
                else
                begin
                    total_next     = total_sum;
                    cmd.start_code = 1'b1;
                    if (unit_len_full == 16'd0)
                    begin
                        unit_done = 1'b1;
                    end
                    else
                    begin
                        data_left_next = unit_len_full;
                        phase_next     = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                cmd.data_en    = 1'b1;
                cmd.data       = b;
                data_left_next = data_left_reg - 16'd1;
                if (data_left_reg == 16'd1)
                    unit_done = 1'b1;
            end
            PH_PPSCNT:
            begin
                units_left_next  = b;
                in_pps_list_next = 1'b1;
                if (b != 8'd0)
                begin
                    pps_next   = 1'b1;
                    phase_next = PH_ULEN_HI;
                end
                else
                begin
                    finished = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_DRAIN;
            end
        endcase

        // Close a unit: next unit, the PPS list, or the end of parsing
        if (unit_done)
        begin
            units_left_next = units_left_reg - 8'd1;
            if (units_left_reg != 8'd1)
                phase_next = PH_ULEN_HI;
            else if (!in_pps_list_reg)
                phase_next = PH_PPSCNT;
            else
                finished = 1'b1;
        end

        // Finish with padding and summary, or drop the rest on failure
        if (finished)
        begin
            cmd.done                 = 1'b1;
            cmd.pad_cnt              = (total_next == 25'd0) ? 6'd0 :
                                       ((pad_bytes > PAD_MAX) ? PAD_MAX : pad_bytes);
            cmd.info.nal_length_size = lfs_next;
            cmd.info.byte_total      = total_next;
            cmd.info.sps_found       = sps_next;
            cmd.info.pps_found       = pps_next;
            phase_next               = PH_DRAIN;
        end
        else if (failed)
        begin
            phase_next = PH_DRAIN;
        end

        cmd.err = failed || (in_data.in_last && (phase_next != PH_DRAIN));

        // Start a new record after the last byte, else advance the position
        if (in_data.in_last)
        begin
            phase_next       = PH_HDR;
            pos_next         = 20'd0;
            units_left_next  = 8'd0;
            in_pps_list_next = 1'b0;
            unit_length_next = 16'd0;
            data_left_next   = 16'd0;
            total_next       = 25'd0;
            lfs_next         = 3'd1;
            sps_next         = 1'b0;
            pps_next         = 1'b0;
        end
        else if (pos_reg != 20'hFFFFF)
        begin
            pos_next = pos_reg + 20'd1;
        end
    end

    assign cmd_push = accept && (cmd.start_code || cmd.data_en || cmd.done || cmd.err);

    // Hold parse state between bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR;
            pos_reg         <= '0;
            units_left_reg  <= '0;
            in_pps_list_reg <= 1'b0;
            unit_length_reg <= '0;
            data_left_reg   <= '0;
            total_reg       <= '0;
            lfs_reg         <= 3'd1;
            sps_reg         <= 1'b0;
            pps_reg         <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            units_left_reg  <= units_left_next;
            in_pps_list_reg <= in_pps_list_next;
            unit_length_reg <= unit_length_next;
            data_left_reg   <= data_left_next;
            total_reg       <= total_next;
            lfs_reg         <= lfs_next;
            sps_reg         <= sps_next;
            pps_reg         <= pps_next;
        end
    end

endmodule

/* design/avcc_cmd_fifo.sv */
// Short request queue between the parser and the emitter.
module avcc_cmd_fifo
    import avcc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  avcc_cmd_t push_data,
    input  logic      pop,
    output avcc_cmd_t head,
    output logic      full,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    avcc_cmd_t     mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // Store pushed requests
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

/* design/avcc_back.sv */
// Emitter: expands each request into start code, data, padding and end items.
module avcc_back
    import avcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  avcc_cmd_t head,
    input  logic      empty,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output avcc_out_t out_data
);

    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] sc_left_reg, sc_left_next;
    logic       data_pend_reg, data_pend_next;
    logic [7:0] data_reg, data_next;
    logic [5:0] pad_left_reg, pad_left_next;
    logic       done_reg, done_next;
    logic       err_reg, err_next;
    avcc_info_t info_reg, info_next;

    logic       out_valid_reg;
    avcc_out_t  out_data_reg;
    avcc_out_t  item;
    logic       end_pend;
    logic       load;

    assign end_pend  = done_reg || err_reg;
    assign load      = cur_valid_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Pick the next item and step the request's counters
    always_comb
    begin
        item           = '0;
        sc_left_next   = sc_left_reg;
        data_pend_next = data_pend_reg;
        data_next      = data_reg;
        pad_left_next  = pad_left_reg;
        done_next      = done_reg;
        err_next       = err_reg;
        info_next      = info_reg;
        cur_valid_next = cur_valid_reg;

        if (sc_left_reg != 3'd0)
        begin
            item.kind     = KIND_BYTE;
            item.out_byte = (sc_left_reg == 3'd1) ? 8'h01 : 8'h00;
            item.last     = (sc_left_reg == 3'd1) && !data_pend_reg &&
                            (pad_left_reg == 6'd0) && !end_pend;
            if (load)
                sc_left_next = sc_left_reg - 3'd1;
        end
        else if (data_pend_reg)
        begin
            item.kind     = KIND_BYTE;
            item.out_byte = data_reg;
            item.last     = (pad_left_reg == 6'd0) && !end_pend;
            if (load)
                data_pend_next = 1'b0;
        end
        else if (pad_left_reg != 6'd0)
        begin
            item.kind = KIND_BYTE;
            item.last = (pad_left_reg == 6'd1) && !end_pend;
            if (load)
                pad_left_next = pad_left_reg - 6'd1;
        end
        else
        begin
            item.kind = done_reg ? KIND_DONE : KIND_ERROR;
            item.last = 1'b1;
            if (done_reg)
            begin
                item.nal_length_size = info_reg.nal_length_size;
                item.byte_total      = info_reg.byte_total;
                item.sps_found       = info_reg.sps_found;
                item.pps_found       = info_reg.pps_found;
            end
        end

        // Take the next request once the current one is spent
        pop = !empty && (!cur_valid_reg || (load && item.last));
        if (pop)
        begin
            cur_valid_next = 1'b1;
            sc_left_next   = head.start_code ? 3'd4 : 3'd0;
            data_pend_next = head.data_en;
            data_next      = head.data;
            pad_left_next  = head.pad_cnt;
            done_next      = head.done;
            err_next       = head.err;
            info_next      = head.info;
        end
        else if (load && item.last)
        begin
            cur_valid_next = 1'b0;
        end
    end

    // Hold request state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            sc_left_reg   <= '0;
            data_pend_reg <= 1'b0;
            pad_left_reg  <= '0;
            done_reg      <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            sc_left_reg   <= sc_left_next;
            data_pend_reg <= data_pend_next;
            pad_left_reg  <= pad_left_next;
            done_reg      <= done_next;
            err_reg       <= err_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        info_reg <= info_next;
        if (load)
            out_data_reg <= item;
    end

endmodule

/* design/avcc_config_to_annexb.sv */
// Top level of the H.264 configuration record to Annex B byte stream converter.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    avcc_in_t  (in_byte, in_last)
//   out       output     out_valid/out_ready  avcc_out_t (kind, out_byte, last, info)
//   cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The parser takes one record byte per cycle; each byte turns into 0 to 37 result
// items, issued one per cycle by the emitter unless out_ready stalls it, behind a
// request queue of CMD_DEPTH. A start code is four output items, so input stalls
// only when the queue fills. A request passes the queue and request registers;
// output items pass through a registered stage, and a stalled output holds its item.
// Reset clears parse state and both registers (record_size and pad_bytes to zero).
module avcc_config_to_annexb
    import avcc_pkg::*;
#(
    parameter int CMD_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  avcc_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output avcc_out_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    logic [19:0] record_size_reg;
    logic [5:0]  pad_bytes_reg;
    avcc_cmd_t   push_cmd, head_cmd;
    logic        cmd_push, cmd_pop, cmd_full, cmd_empty;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_size_reg <= '0;
            pad_bytes_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RECORD_SIZE: record_size_reg <= cfg_data;
                REG_PAD_BYTES:   pad_bytes_reg   <= cfg_data[5:0];
                default:         ;
            endcase
        end
    end

    avcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .record_size (record_size_reg),
        .pad_bytes   (pad_bytes_reg),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd         (push_cmd)
    );

    avcc_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_cmd),
        .pop       (cmd_pop),
        .head      (head_cmd),
        .full      (cmd_full),
        .empty     (cmd_empty)
    );

    avcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_cmd),
        .empty     (cmd_empty),
        .pop       (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
